### hdl/drsf_pkg.sv
// Shared types, constants and register codes of the dirty row span finder.
`default_nettype none
package drsf_pkg;

  localparam int unsigned MaxSpanCountDef = 32;
  localparam int unsigned MaxFrameRowsDef = 1024;

  localparam int unsigned WordW      = 32;
  localparam int unsigned WprW       = 10;
  localparam int unsigned RpfW       = 11;
  localparam int unsigned WordIdxW   = 9;
  localparam int unsigned RowFieldW  = 10;
  localparam int unsigned CountW     = 6;
  localparam int unsigned CfgDataW   = 11;
  localparam int unsigned RowWordsCap = 512;

  localparam logic [WprW-1:0] WprReset = WprW'(120);
  localparam logic [RpfW-1:0] RpfReset = RpfW'(320);

  typedef enum logic [0:0] {
    CfgWordsPerRow  = 1'b0,
    CfgRowsPerFrame = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [WordW-1:0] new_word;
    logic [WordW-1:0] old_word;
  } in_req_t;

  typedef struct packed {
    logic                 span_valid;
    logic [RowFieldW-1:0] span_first_row;
    logic [RowFieldW-1:0] span_last_row;
    logic [CountW-1:0]    spans_so_far;
    logic                 frame_end;
  } out_req_t;

  typedef struct packed {
    logic valid;
    logic differ;
  } word_stage_t;

endpackage
`default_nettype wire

### hdl/dirty_row_span_finder_top.sv
// Top level of the dirty row span finder.
`default_nettype none
// The block takes one new/old framebuffer word pair per request, row-major, and reports runs
// of consecutive dirty rows as spans, one request per closed span; the frame's last word gives
// one request marked frame_end, which also carries any span that closes there. An item passes
// the compare register and then the output register of the span tracker, where its result is
// offered, and a new word is taken every cycle while the result side keeps up; while a result
// waits in the output register, words that give no result keep flowing in, and the next word
// that gives a result waits in the compare register.
module dirty_row_span_finder_top #(
  parameter int unsigned MAX_SPAN_COUNT = drsf_pkg::MaxSpanCountDef,
  parameter int unsigned MAX_FRAME_ROWS = drsf_pkg::MaxFrameRowsDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire drsf_pkg::cfg_idx_e            cfg_index_i,
  input  wire logic [drsf_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire drsf_pkg::in_req_t             in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output drsf_pkg::out_req_t                 out_data_o
);

  drsf_pkg::word_stage_t stage;
  logic                  take;

  drsf_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .stage_o    (stage),
    .take_i     (take)
  );

  drsf_span_tracker #(
    .MAX_SPAN_COUNT (MAX_SPAN_COUNT),
    .MAX_FRAME_ROWS (MAX_FRAME_ROWS)
  ) u_span_tracker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .stage_i     (stage),
    .take_o      (take),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire

### hdl/drsf_in_stage.sv
// Input register stage that compares each word pair and holds the result.
`default_nettype none
module drsf_in_stage (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire drsf_pkg::in_req_t     in_data_i,
  output drsf_pkg::word_stage_t      stage_o,
  input  wire logic                  take_i
);

  logic valid_q, valid_d;
  logic differ_q, differ_d;
  logic accept;

  assign in_stall_o = valid_q & ~take_i;
  assign accept     = in_valid_i & ~in_stall_o;

  always_comb begin
    valid_d  = valid_q;
    differ_d = differ_q;
    if (accept) begin
      valid_d  = 1'b1;
      differ_d = (in_data_i.new_word != in_data_i.old_word);
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    differ_q <= differ_d;
  end

  assign stage_o.valid  = valid_q;
  assign stage_o.differ = differ_q;

endmodule
`default_nettype wire

### hdl/drsf_span_tracker.sv
// Row and span tracking state, configuration registers and the result register.
`default_nettype none
module drsf_span_tracker #(
  parameter int unsigned MAX_SPAN_COUNT = drsf_pkg::MaxSpanCountDef,
  parameter int unsigned MAX_FRAME_ROWS = drsf_pkg::MaxFrameRowsDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire drsf_pkg::cfg_idx_e            cfg_index_i,
  input  wire logic [drsf_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire drsf_pkg::word_stage_t         stage_i,
  output logic                               take_o,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output drsf_pkg::out_req_t                 out_data_o
);

  localparam int unsigned RowW = (MAX_FRAME_ROWS > 1) ? $clog2(MAX_FRAME_ROWS) : 1;
  localparam int unsigned CmpW = (RowW + 1 > drsf_pkg::RpfW) ? RowW + 1 : drsf_pkg::RpfW;
  localparam int unsigned ExtW = (RowW > drsf_pkg::RowFieldW) ? RowW : drsf_pkg::RowFieldW;

  logic [drsf_pkg::WprW-1:0]     wpr_q;
  logic [drsf_pkg::RpfW-1:0]     rpf_q;
  logic [drsf_pkg::WordIdxW-1:0] word_q, word_d;
  logic [RowW-1:0]               row_q, row_d;
  logic                          change_q, change_d;
  logic                          open_q, open_d;
  logic [RowW-1:0]               start_q, start_d;
  logic [drsf_pkg::CountW-1:0]   total_q, total_d;
  logic                          out_valid_q, out_valid_d;
  drsf_pkg::out_req_t            out_q, out_d;

  logic [drsf_pkg::WprW-1:0]     wpr_c;
  logic [CmpW-1:0]               rpf_c;
  logic [drsf_pkg::WprW-1:0]     word_next;
  logic [CmpW-1:0]               row_next;
  logic                          dirty, row_end, frame_last, emit, res_valid, advance;
  logic [RowW-1:0]               first_row, last_row;
  logic [ExtW-1:0]               first_ext, last_ext;
  drsf_pkg::out_req_t            res;

  always_comb begin
    wpr_c = wpr_q;
    if (wpr_q == '0) begin
      wpr_c = drsf_pkg::WprW'(1);
    end else if (wpr_q > drsf_pkg::WprW'(drsf_pkg::RowWordsCap)) begin
      wpr_c = drsf_pkg::WprW'(drsf_pkg::RowWordsCap);
    end
    rpf_c = CmpW'(rpf_q);
    if (rpf_q == '0) begin
      rpf_c = CmpW'(1);
    end else if (CmpW'(rpf_q) > CmpW'(MAX_FRAME_ROWS)) begin
      rpf_c = CmpW'(MAX_FRAME_ROWS);
    end
  end

  assign word_next  = drsf_pkg::WprW'(word_q) + drsf_pkg::WprW'(1);
  assign row_next   = CmpW'(row_q) + CmpW'(1);
  assign dirty      = change_q | stage_i.differ;
  assign row_end    = ~(word_next < wpr_c);
  assign frame_last = (row_next >= rpf_c);

  always_comb begin
    word_d    = word_q;
    row_d     = row_q;
    change_d  = change_q;
    open_d    = open_q;
    start_d   = start_q;
    total_d   = total_q;
    emit      = 1'b0;
    first_row = '0;
    last_row  = '0;
    res_valid = 1'b0;
    if (!row_end) begin
      word_d   = word_next[drsf_pkg::WordIdxW-1:0];
      change_d = dirty;
    end else begin
      word_d   = '0;
      change_d = 1'b0;
      if (dirty) begin
        if (!open_q && (total_q < drsf_pkg::CountW'(MAX_SPAN_COUNT))) begin
          open_d  = 1'b1;
          start_d = row_q;
        end
      end else if (open_q) begin
        emit      = 1'b1;
        first_row = start_q;
        last_row  = row_q - RowW'(1);
        total_d   = total_q + drsf_pkg::CountW'(1);
        open_d    = 1'b0;
      end
      if (frame_last) begin
        if (!emit && open_d) begin
          emit      = 1'b1;
          first_row = start_d;
          last_row  = row_q;
          total_d   = total_d + drsf_pkg::CountW'(1);
        end
        res_valid = 1'b1;
        row_d     = '0;
        total_d   = '0;
        open_d    = 1'b0;
        start_d   = '0;
      end else begin
        row_d     = row_next[RowW-1:0];
        res_valid = emit;
      end
    end
  end

  assign first_ext = ExtW'(first_row);
  assign last_ext  = ExtW'(last_row);

  always_comb begin
    res.span_valid     = emit;
    res.span_first_row = emit ? first_ext[drsf_pkg::RowFieldW-1:0] : '0;
    res.span_last_row  = emit ? last_ext[drsf_pkg::RowFieldW-1:0] : '0;
    res.spans_so_far   = frame_last ? (emit ? total_q + drsf_pkg::CountW'(1) : total_q)
                                    : total_d;
    res.frame_end      = frame_last;
  end

  assign advance = stage_i.valid & (~res_valid | ~out_valid_q | ~out_stall_i);
  assign take_o  = advance;

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (advance && res_valid) begin
      out_valid_d = 1'b1;
      out_d       = res;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wpr_q       <= drsf_pkg::WprReset;
      rpf_q       <= drsf_pkg::RpfReset;
      word_q      <= '0;
      row_q       <= '0;
      change_q    <= 1'b0;
      open_q      <= 1'b0;
      start_q     <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          drsf_pkg::CfgWordsPerRow:  wpr_q <= cfg_data_i[drsf_pkg::WprW-1:0];
          drsf_pkg::CfgRowsPerFrame: rpf_q <= cfg_data_i[drsf_pkg::RpfW-1:0];
          default: ;
        endcase
      end
      if (advance) begin
        word_q   <= word_d;
        row_q    <= row_d;
        change_q <= change_d;
        open_q   <= open_d;
        start_q  <= start_d;
        total_q  <= total_d;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire
